/* hw/rtl/adsr_pkg.sv */
// Shared types and constants for the ADSR envelope and stereo VCA block.
`default_nettype none

package adsr_pkg;

	localparam int SAMPLE_BITS_DEF     = 16;
	localparam int LEVEL_FRAC_BITS_DEF = 16;

	// Width and reset of every configuration register
	localparam int               CFG_W     = 17;
	localparam logic [CFG_W-1:0] CFG_RESET = 17'h10000;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	typedef enum logic [1:0] {
		REG_ATTACK  = 2'd0,
		REG_DECAY   = 2'd1,
		REG_SUSTAIN = 2'd2,
		REG_RELEASE = 2'd3
	} cfg_idx_e;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_NOTE_ON = 2'd1,
		OP_RELEASE = 2'd2,
		OP_STOP    = 2'd3
	} opcode_e;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_ATTACK  = 3'd1,
		ST_DECAY   = 3'd2,
		ST_SUSTAIN = 3'd3,
		ST_RELEASE = 3'd4
	} stage_e;

	// Per-beat status that rides along with the level
	typedef struct packed {
		stage_e stage;
		logic   went_idle;
	} env_meta_t;

endpackage

`default_nettype wire

/* hw/rtl/adsr_if.sv */
// Valid/ready channel interfaces for input items and result beats.
`default_nettype none

interface adsr_item_if import adsr_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    opcode;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;

	modport source (output valid, opcode, left_in, right_in, input ready);
	modport sink   (input valid, opcode, left_in, right_in, output ready);
endinterface

interface adsr_result_if import adsr_pkg::*; #(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	logic [LEVEL_FRAC_BITS:0]      env_level;
	logic [2:0]                    env_stage;
	logic                          went_idle;

	modport source (output valid, left_out, right_out, env_level, env_stage, went_idle,
		input ready);
	modport sink   (input valid, left_out, right_out, env_level, env_stage, went_idle,
		output ready);
endinterface

`default_nettype wire

/* hw/rtl/adsr_cfg.sv */
// APB register file with clamped step values and a precomputed decay decrement.
`default_nettype none

module adsr_cfg import adsr_pkg::*; #(
	parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF,
	localparam int LW = LEVEL_FRAC_BITS + 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output logic      [LW-1:0]     attack_c,
	output logic      [LW-1:0]     decay_dec,
	output logic      [LW-1:0]     sus_c,
	output logic      [LW-1:0]     release_c
);

	localparam int XW = (CFG_W > LW) ? CFG_W : LW;
	localparam logic [XW-1:0] ONE_X = {{(XW-1){1'b0}}, 1'b1} << LEVEL_FRAC_BITS;
	localparam logic [LW-1:0] ONE_L = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

	// Clamp to 0..ONE, or to 1..ONE for a step
	function automatic logic [LW-1:0] clamp_val(input logic [CFG_W-1:0] v, input logic floor1);
		logic [XW-1:0] x;
		x = XW'(v);
		if (floor1 && (x == '0)) x = {{(XW-1){1'b0}}, 1'b1};
		if (x > ONE_X) x = ONE_X;
		return x[LW-1:0];
	endfunction

	// ceil(step * (ONE - sustain) / ONE)
	function automatic logic [LW-1:0] dec_calc(input logic [CFG_W-1:0] step_raw,
		input logic [CFG_W-1:0] sus_raw);
		logic [LW-1:0]   s;
		logic [LW-1:0]   d;
		logic [2*LW-1:0] p;
		s = clamp_val(step_raw, 1'b1);
		d = ONE_L - clamp_val(sus_raw, 1'b0);
		p = (2*LW)'(s) * (2*LW)'(d);
		p = p + (2*LW)'(ONE_L - 1'b1);
		return p[LEVEL_FRAC_BITS +: LW];
	endfunction

	localparam logic [LW-1:0] DEC_RST = dec_calc(CFG_RESET, CFG_RESET);

	logic [CFG_W-1:0] attack_q, decay_q, sus_q, release_q;
	logic [LW-1:0]    dec_q;
	logic             wr;
	cfg_idx_e         idx;
	logic [CFG_W-1:0] wdata;
	logic [CFG_W-1:0] mul_step, mul_sus;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = cfg_idx_e'(paddr[3:2]);
	assign wdata  = pwdata[CFG_W-1:0];

	// Feed the multiplier with the value about to be written
	assign mul_step = (idx == REG_DECAY)   ? wdata : decay_q;
	assign mul_sus  = (idx == REG_SUSTAIN) ? wdata : sus_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= CFG_RESET;
			decay_q   <= CFG_RESET;
			sus_q     <= CFG_RESET;
			release_q <= CFG_RESET;
			dec_q     <= DEC_RST;
		end else if (wr) begin
			case (idx)
				REG_ATTACK:  attack_q <= wdata;
				REG_DECAY: begin
					decay_q <= wdata;
					dec_q   <= dec_calc(mul_step, mul_sus);
				end
				REG_SUSTAIN: begin
					sus_q <= wdata;
					dec_q <= dec_calc(mul_step, mul_sus);
				end
				REG_RELEASE: release_q <= wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ATTACK:  prdata = APB_DW'(attack_q);
			REG_DECAY:   prdata = APB_DW'(decay_q);
			REG_SUSTAIN: prdata = APB_DW'(sus_q);
			REG_RELEASE: prdata = APB_DW'(release_q);
			default:     prdata = '0;
		endcase
	end

	assign attack_c  = clamp_val(attack_q, 1'b1);
	assign release_c = clamp_val(release_q, 1'b1);
	assign sus_c     = clamp_val(sus_q, 1'b0);
	assign decay_dec = dec_q;

endmodule

`default_nettype wire

/* hw/rtl/adsr_ctrl.sv */
// Envelope state machine: one level update per accepted beat, result into stage 1.
`default_nettype none

module adsr_ctrl import adsr_pkg::*; #(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF,
	localparam int LW = LEVEL_FRAC_BITS + 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [1:0]                    opcode,
	input  wire logic signed [SAMPLE_BITS-1:0] left_in,
	input  wire logic signed [SAMPLE_BITS-1:0] right_in,
	input  wire logic [LW-1:0]                 attack_c,
	input  wire logic [LW-1:0]                 decay_dec,
	input  wire logic [LW-1:0]                 sus_c,
	input  wire logic [LW-1:0]                 release_c,
	output logic      [LW-1:0]                 level_s1,
	output env_meta_t                          meta_s1,
	output logic signed [SAMPLE_BITS-1:0]      left_s1,
	output logic signed [SAMPLE_BITS-1:0]      right_s1
);

	localparam logic [LW-1:0] ONE_L = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

	stage_e               stage_q, stage_n;
	logic [LW-1:0]        level_q, level_n;
	logic                 went;
	logic                 tick;
	opcode_e              op;
	logic [LW:0]          sum;
	logic signed [LW:0]   dec_diff, rel_diff;

	assign op       = opcode_e'(opcode);
	assign sum      = {1'b0, level_q} + {1'b0, attack_c};
	assign dec_diff = $signed({1'b0, level_q}) - $signed({1'b0, decay_dec});
	assign rel_diff = $signed({1'b0, level_q}) - $signed({1'b0, release_c});

	always_comb begin
		stage_n = stage_q;
		level_n = level_q;
		went    = 1'b0;
		tick    = 1'b0;
		case (op)
			OP_TICK: begin
				tick = 1'b1;
				case (stage_q)
					ST_ATTACK: begin
						if (sum >= {1'b0, ONE_L}) begin
							level_n = ONE_L;
							stage_n = ST_DECAY;
						end else begin
							level_n = sum[LW-1:0];
						end
					end
					ST_DECAY: begin
						if (dec_diff <= $signed({1'b0, sus_c})) begin
							level_n = sus_c;
							stage_n = ST_SUSTAIN;
						end else begin
							level_n = dec_diff[LW-1:0];
						end
					end
					ST_SUSTAIN: level_n = sus_c;
					ST_RELEASE: begin
						if (rel_diff <= 0) begin
							level_n = '0;
							stage_n = ST_IDLE;
							went    = 1'b1;
						end else begin
							level_n = rel_diff[LW-1:0];
						end
					end
					default: begin
						level_n = '0;
						stage_n = ST_IDLE;
					end
				endcase
			end
			OP_NOTE_ON: begin
				stage_n = ST_ATTACK;
				level_n = '0;
			end
			OP_RELEASE: stage_n = ST_RELEASE;
			OP_STOP: begin
				went    = (stage_q != ST_IDLE);
				stage_n = ST_IDLE;
				level_n = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_IDLE;
			level_q <= '0;
		end else if (accept) begin
			stage_q <= stage_n;
			level_q <= level_n;
		end
	end

	// Note events pass zero samples down the lanes
	always_ff @(posedge clk) begin
		if (accept) begin
			level_s1          <= level_n;
			meta_s1.stage     <= stage_n;
			meta_s1.went_idle <= went;
			left_s1           <= tick ? left_in : '0;
			right_s1          <= tick ? right_in : '0;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/adsr_lane.sv */
// One VCA lane: sample times level, floor shift and saturate.
`default_nettype none

module adsr_lane import adsr_pkg::*; #(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF,
	localparam int LW = LEVEL_FRAC_BITS + 1
) (
	input  wire logic                          clk,
	input  wire logic                          load,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire logic [LW-1:0]                 level,
	output logic signed [SAMPLE_BITS-1:0]      scaled
);

	localparam int PW = SAMPLE_BITS + LW + 1;
	localparam logic signed [PW-1:0] MAXV =
		{{(PW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [PW-1:0] MINV = ~MAXV;

	logic signed [PW-1:0] prod_s2;
	logic signed [PW-1:0] shifted;

	always_ff @(posedge clk) begin
		if (load) prod_s2 <= PW'(sample) * $signed(PW'({1'b0, level}));
	end

	// Arithmetic shift rounds toward minus infinity
	assign shifted = prod_s2 >>> LEVEL_FRAC_BITS;

	always_comb begin
		if (shifted > MAXV)      scaled = MAXV[SAMPLE_BITS-1:0];
		else if (shifted < MINV) scaled = MINV[SAMPLE_BITS-1:0];
		else                     scaled = shifted[SAMPLE_BITS-1:0];
	end

endmodule

`default_nettype wire

/* hw/rtl/adsr_merge.sv */
// Joins both lanes with level and stage into the registered result beat.
`default_nettype none

module adsr_merge import adsr_pkg::*; #(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF,
	localparam int LW = LEVEL_FRAC_BITS + 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire logic signed [SAMPLE_BITS-1:0] left_lane,
	input  wire logic signed [SAMPLE_BITS-1:0] right_lane,
	input  wire logic [LW-1:0]                 level,
	input  wire env_meta_t                     meta,
	output logic                               free,
	adsr_result_if.source                      result
);

	logic                          valid_q;
	logic signed [SAMPLE_BITS-1:0] left_q, right_q;
	logic [LW-1:0]                 level_q;
	env_meta_t                     meta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			left_q  <= left_lane;
			right_q <= right_lane;
			level_q <= level;
			meta_q  <= meta;
		end
	end

	assign free             = !valid_q || result.ready;
	assign result.valid     = valid_q;
	assign result.left_out  = left_q;
	assign result.right_out = right_q;
	assign result.env_level = level_q;
	assign result.env_stage = meta_q.stage;
	assign result.went_idle = meta_q.went_idle;

endmodule

`default_nettype wire

/* hw/rtl/adsr_envelope_vca_top.sv */
// Top level of the linear ADSR envelope with stereo VCA lanes.
//
//  channel  | dir | handshake          | beat contents
//  ---------+-----+--------------------+-------------------------------------------
//  item     | in  | valid/ready        | opcode, left_in, right_in
//  result   | out | valid/ready        | left_out, right_out, env_level, env_stage,
//           |     |                    | went_idle
//  apb      | in  | psel/penable/pready| attack, decay, sustain, release registers
//
// One beat per cycle unless the output stalls; items pass stage 1 and the lane stage
// to the result register. The level loop closes through level_q; the decay decrement
// multiply runs at register write time, the two sample multiplies sit in the lane stage.
// Reset clears stage, level, valid bits and restores all registers to 65536.
// A stalled result holds; items keep flowing into empty stages until the pipe is full.
`default_nettype none

module adsr_envelope_vca_top import adsr_pkg::*; #(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	adsr_item_if.sink              item,
	adsr_result_if.source          result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	localparam int LW = LEVEL_FRAC_BITS + 1;

	logic [LW-1:0]                 attack_c, decay_dec, sus_c, release_c;
	logic [LW-1:0]                 level_s1, level_s2;
	env_meta_t                     meta_s1, meta_s2;
	logic signed [SAMPLE_BITS-1:0] left_s1, right_s1;
	logic signed [SAMPLE_BITS-1:0] left_lane, right_lane;
	logic                          v1_q, v2_q;
	logic                          adv1, adv2, free, accept, lane_load;

	adsr_cfg #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.attack_c  (attack_c),
		.decay_dec (decay_dec),
		.sus_c     (sus_c),
		.release_c (release_c)
	);

	// Stage advance: each stage moves when the one after it has room
	assign adv2       = !v2_q || free;
	assign adv1       = !v1_q || adv2;
	assign item.ready = adv1;
	assign accept     = item.valid && adv1;
	assign lane_load  = adv2 && v1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (adv1) v1_q <= accept;
			if (adv2) v2_q <= v1_q;
		end
	end

	adsr_ctrl #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.opcode    (item.opcode),
		.left_in   (item.left_in),
		.right_in  (item.right_in),
		.attack_c  (attack_c),
		.decay_dec (decay_dec),
		.sus_c     (sus_c),
		.release_c (release_c),
		.level_s1  (level_s1),
		.meta_s1   (meta_s1),
		.left_s1   (left_s1),
		.right_s1  (right_s1)
	);

	adsr_lane #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
	) u_lane_left (
		.clk    (clk),
		.load   (lane_load),
		.sample (left_s1),
		.level  (level_s1),
		.scaled (left_lane)
	);

	adsr_lane #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
	) u_lane_right (
		.clk    (clk),
		.load   (lane_load),
		.sample (right_s1),
		.level  (level_s1),
		.scaled (right_lane)
	);

	always_ff @(posedge clk) begin
		if (lane_load) begin
			level_s2 <= level_s1;
			meta_s2  <= meta_s1;
		end
	end

	adsr_merge #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (free && v2_q),
		.left_lane  (left_lane),
		.right_lane (right_lane),
		.level      (level_s2),
		.meta       (meta_s2),
		.free       (free),
		.result     (result)
	);

endmodule

`default_nettype wire

/* hw/rtl/adsr_checker.sv */
// Port-level assertions for the envelope top level, bound into it.
`default_nettype none

module adsr_checker import adsr_pkg::*; #(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          item_ready,
	input wire logic                          result_valid,
	input wire logic                          result_ready,
	input wire logic signed [SAMPLE_BITS-1:0] left_out,
	input wire logic signed [SAMPLE_BITS-1:0] right_out,
	input wire logic [LEVEL_FRAC_BITS:0]      env_level,
	input wire logic [2:0]                    env_stage,
	input wire logic                          went_idle
);

	// A beat that reports entering idle must show the idle stage
	a_went_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && went_idle |-> env_stage == ST_IDLE)
		else $error("went_idle without idle stage");

	// Idle always carries a zero level
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && env_stage == ST_IDLE |-> env_level == '0)
		else $error("idle stage with nonzero level");

	// Input backpressure only when the output is blocked
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid && !result_ready)
		else $error("item stalled while result side free");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(left_out)
			&& $stable(right_out) && $stable(env_level) && $stable(env_stage)
			&& $stable(went_idle))
		else $error("stalled result beat changed");

endmodule

bind adsr_envelope_vca_top adsr_checker #(
	.SAMPLE_BITS     (SAMPLE_BITS),
	.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
) u_adsr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.left_out     (result.left_out),
	.right_out    (result.right_out),
	.env_level    (result.env_level),
	.env_stage    (result.env_stage),
	.went_idle    (result.went_idle)
);

`default_nettype wire

/* sim/adsr_envelope_vca_checker.sv */
// Scoreboard for the ADSR envelope block: tracks registers, predicts each beat, compares results.
`timescale 1ns / 100ps

module adsr_envelope_vca_checker import adsr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	adsr_item_if                   item,
	adsr_result_if                 result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic              pready,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output int                     errors,
	output int                     outstanding
);

	localparam int     SW       = SAMPLE_BITS_DEF;
	localparam int     FW       = LEVEL_FRAC_BITS_DEF;
	localparam longint UNITY    = longint'(1) << FW;
	localparam longint SAMP_MAX = (longint'(1) << (SW - 1)) - 1;
	localparam longint SAMP_MIN = -SAMP_MAX - 1;

	typedef struct packed {
		logic signed [SW-1:0] left;
		logic signed [SW-1:0] right;
		logic [FW:0]          level;
		logic [2:0]           stage;
		logic                 went;
	} env_beat_t;

	logic [CFG_W-1:0] attack_q  = CFG_RESET;
	logic [CFG_W-1:0] decay_q   = CFG_RESET;
	logic [CFG_W-1:0] sustain_q = CFG_RESET;
	logic [CFG_W-1:0] release_q = CFG_RESET;
	stage_e           stage_q   = ST_IDLE;
	longint           level_q   = 0;

	env_beat_t beats_q[$];
	env_beat_t want_b;
	int        fail_cnt = 0;
	int        open_cnt = 0;

	assign errors      = fail_cnt;
	assign outstanding = open_cnt;

	// zero counts as one, anything above unity counts as unity
	function automatic longint eff_step(logic [CFG_W-1:0] v);
		longint s;
		s = longint'(v);
		if (s < 1) s = 1;
		if (s > UNITY) s = UNITY;
		return s;
	endfunction

	function automatic logic signed [SW-1:0] vca_scale(logic signed [SW-1:0] x, longint lvl);
		longint p;
		p = longint'(x) * lvl;
		p = p >>> FW;
		if (p > SAMP_MAX) p = SAMP_MAX;
		if (p < SAMP_MIN) p = SAMP_MIN;
		return p[SW-1:0];
	endfunction

	function automatic env_beat_t advance_envelope(opcode_e op, logic signed [SW-1:0] l,
		logic signed [SW-1:0] r);
		env_beat_t b;
		longint    sus;
		sus    = (longint'(sustain_q) > UNITY) ? UNITY : longint'(sustain_q);
		b.left  = '0;
		b.right = '0;
		b.went  = 1'b0;
		case (op)
			OP_TICK: begin
				case (stage_q)
					ST_ATTACK: begin
						level_q += eff_step(attack_q);
						if (level_q >= UNITY) begin
							level_q = UNITY;
							stage_q = ST_DECAY;
						end
					end
					ST_DECAY: begin
						// decrement rounds up
						level_q -= (eff_step(decay_q) * (UNITY - sus) + UNITY - 1) / UNITY;
						if (level_q <= sus) begin
							level_q = sus;
							stage_q = ST_SUSTAIN;
						end
					end
					ST_SUSTAIN: level_q = sus;
					ST_RELEASE: begin
						level_q -= eff_step(release_q);
						if (level_q <= 0) begin
							level_q = 0;
							stage_q = ST_IDLE;
							b.went  = 1'b1;
						end
					end
					default: begin
						stage_q = ST_IDLE;
						level_q = 0;
					end
				endcase
				if (level_q < 0) level_q = 0;
				if (level_q > UNITY) level_q = UNITY;
				b.left  = vca_scale(l, level_q);
				b.right = vca_scale(r, level_q);
			end
			OP_NOTE_ON: begin
				stage_q = ST_ATTACK;
				level_q = 0;
			end
			OP_RELEASE: stage_q = ST_RELEASE;
			default: begin
				b.went  = (stage_q != ST_IDLE);
				stage_q = ST_IDLE;
				level_q = 0;
			end
		endcase
		b.level = level_q[FW:0];
		b.stage = stage_q;
		return b;
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  = CFG_RESET;
			decay_q   = CFG_RESET;
			sustain_q = CFG_RESET;
			release_q = CFG_RESET;
			stage_q   = ST_IDLE;
			level_q   = 0;
			beats_q.delete();
			open_cnt  = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (beats_q.size() == 0) begin
					$error("result beat with no item outstanding");
					fail_cnt++;
				end else begin
					want_b = beats_q.pop_front();
					check_field("left_out", longint'(want_b.left), longint'(result.left_out));
					check_field("right_out", longint'(want_b.right), longint'(result.right_out));
					check_field("env_level", longint'(want_b.level), longint'(result.env_level));
					check_field("env_stage", longint'(want_b.stage), longint'(result.env_stage));
					check_field("went_idle", longint'(want_b.went), longint'(result.went_idle));
				end
			end
			if (item.valid && item.ready)
				beats_q.push_back(advance_envelope(opcode_e'(item.opcode), item.left_in,
					item.right_in));
			if (psel && penable && pwrite && pready) begin
				case (cfg_idx_e'(paddr[APB_AW-1:2]))
					REG_ATTACK:  attack_q  = pwdata[CFG_W-1:0];
					REG_DECAY:   decay_q   = pwdata[CFG_W-1:0];
					REG_SUSTAIN: sustain_q = pwdata[CFG_W-1:0];
					REG_RELEASE: release_q = pwdata[CFG_W-1:0];
					default: ;
				endcase
			end
			open_cnt = beats_q.size();
		end
	end

endmodule

/* sim/tb_adsr_envelope_vca_top.sv */
// Testbench top for the ADSR envelope block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_adsr_envelope_vca_top import adsr_pkg::*; ();

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 200;
	localparam int HOLD_CYCLES = 400;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int errors;
	int outstanding;
	int cycle_cnt    = 0;
	bit no_gaps      = 1'b0;
	int holdoff_req  = 0;
	int holdoff_done = 0;
	int holdoff_left = 0;

	adsr_item_if   item_ch ();
	adsr_result_if result_ch ();

	adsr_envelope_vca_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	adsr_envelope_vca_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off on request to back up the pipe
	always @(negedge clk) begin
		if (holdoff_left > 0) begin
			result_ch.ready = 1'b0;
			holdoff_left    = holdoff_left - 1;
		end else if (holdoff_done != holdoff_req) begin
			holdoff_done    = holdoff_done + 1;
			holdoff_left    = HOLD_CYCLES - 1;
			result_ch.ready = 1'b0;
		end else begin
			result_ch.ready = no_gaps || ($urandom_range(99) >= 17);
		end
	end

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(9))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			3:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_step();
		case ($urandom_range(9))
			0:       return '0;
			1:       return 17'd1;
			2:       return 17'd65536;
			3:       return 17'($urandom_range(65537, 131071));
			default: return 17'($urandom_range(1500, 65536));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_sustain();
		case ($urandom_range(9))
			0:       return '0;
			1:       return 17'd65536;
			2:       return 17'($urandom_range(65537, 131071));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_item(opcode_e op, logic [15:0] l, logic [15:0] r);
		while (!no_gaps && $urandom_range(99) < 17) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid    = 1'b1;
		item_ch.opcode   = op;
		item_ch.left_in  = l;
		item_ch.right_in = r;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	task automatic apb_write(cfg_idx_e idx, logic [CFG_W-1:0] val);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = APB_DW'(val);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Drop valid, let every outstanding beat drain, then leave slack before returning
	task automatic wait_drained();
		item_ch.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_envelope(logic [CFG_W-1:0] att, logic [CFG_W-1:0] dec,
		logic [CFG_W-1:0] sus, logic [CFG_W-1:0] rel);
		wait_drained();
		apb_write(REG_ATTACK, att);
		apb_write(REG_DECAY, dec);
		apb_write(REG_SUSTAIN, sus);
		apb_write(REG_RELEASE, rel);
	endtask

	task automatic tick(logic [15:0] l, logic [15:0] r);
		send_item(OP_TICK, l, r);
	endtask

	// Mostly complete notes with random content, the rest single random beats
	task automatic play_notes(int budget);
		int sent;
		int n;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(99) < 80) begin
				send_item(OP_NOTE_ON, rand_sample(), rand_sample());
				n = $urandom_range(1, 60);
				repeat (n) tick(rand_sample(), rand_sample());
				sent += n + 1;
				if ($urandom_range(9) != 0) begin
					send_item(OP_RELEASE, rand_sample(), rand_sample());
					n = $urandom_range(0, 50);
					repeat (n) tick(rand_sample(), rand_sample());
					sent += n + 1;
				end
				if ($urandom_range(4) == 0) begin
					send_item(OP_STOP, rand_sample(), rand_sample());
					sent++;
				end
			end else begin
				send_item(opcode_e'($urandom_range(3)), rand_sample(), rand_sample());
				sent++;
			end
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		item_ch.valid    = 1'b0;
		item_ch.opcode   = OP_TICK;
		item_ch.left_in  = '0;
		item_ch.right_in = '0;
		result_ch.ready  = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset registers: instant attack, sustain at unity, instant release
		tick(16'h7FFF, 16'h8000);
		send_item(OP_NOTE_ON, 16'hFFFF, 16'h0000);
		tick(16'h7FFF, 16'h8000);
		tick(16'hFFFF, 16'h0001);
		tick(16'h8000, 16'h7FFF);
		send_item(OP_RELEASE, 16'h5555, 16'hAAAA);
		tick(16'h1234, 16'hEDCB);
		send_item(OP_STOP, 16'h0000, 16'hFFFF);
		// release from idle ends on the next tick
		send_item(OP_RELEASE, 16'h0000, 16'h0000);
		tick(16'h7FFF, 16'h7FFF);
		send_item(OP_NOTE_ON, 16'h0000, 16'h0000);
		send_item(OP_STOP, 16'h0000, 16'h0000);
		send_item(OP_RELEASE, 16'h0000, 16'h0000);
		send_item(OP_STOP, 16'hFFFF, 16'hFFFF);

		// Zero steps count as one, oversized release counts as unity
		set_envelope('0, '0, '0, 17'h1FFFF);
		send_item(OP_NOTE_ON, 16'h0000, 16'h0000);
		tick(16'hFFFF, 16'h0001);
		tick(16'hFFFF, 16'h0001);
		send_item(OP_RELEASE, 16'h0000, 16'h0000);
		tick(16'h8000, 16'h7FFF);

		// Oversized attack, minimal decay at half sustain
		set_envelope(17'h1FFFF, '0, 17'd32768, 17'd1);
		send_item(OP_NOTE_ON, 16'h0000, 16'h0000);
		tick(16'h7FFF, 16'h8000);
		tick(16'h7FFF, 16'h8000);
		send_item(OP_STOP, 16'h0000, 16'h0000);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				1:       set_envelope('0, '0, '0, '0);
				2:       set_envelope(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
				5:       set_envelope(CFG_RESET, CFG_RESET, CFG_RESET, CFG_RESET);
				default: set_envelope(pick_step(), pick_step(), pick_sustain(), pick_step());
			endcase
			no_gaps = (ph == 3);
			if (ph == 4) begin
				play_notes(PHASE_ITEMS / 2);
				holdoff_req = holdoff_req + 1;
				play_notes(PHASE_ITEMS / 2);
			end else begin
				play_notes(PHASE_ITEMS);
			end
		end
		no_gaps = 1'b0;

		wait_drained();
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/adsr_pkg.sv
hw/rtl/adsr_if.sv
hw/rtl/adsr_cfg.sv
hw/rtl/adsr_ctrl.sv
hw/rtl/adsr_lane.sv
hw/rtl/adsr_merge.sv
hw/rtl/adsr_envelope_vca_top.sv
hw/rtl/adsr_checker.sv
sim/adsr_envelope_vca_checker.sv
sim/tb_adsr_envelope_vca_top.sv
